// ===== hw/rtl/psa_pkg.sv =====
package psa_pkg;

   // long division of (age * frames) << 16 by life span
   localparam int DQ_W      = 56;
   localparam int DEN_W     = 31;
   localparam int DIV_STEPS = 4;
   localparam int DIV_STAGES = DQ_W / DIV_STEPS;

   typedef enum logic [0:0] {
      REG_GRAVITY = 1'b0,
      REG_ROWS    = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] gravity_scale;
      logic [30:0]        life_span;
      logic [30:0]        age;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_y;
      logic [30:0]        new_age;
      logic               alive;
      logic [15:0]        frame_u;
      logic [15:0]        frame_v;
      logic [15:0]        next_frame_u;
      logic [15:0]        next_frame_v;
      logic [15:0]        frame_blend;
   } rsp_type;

   typedef struct packed {
      logic [3:0] row;
      logic [3:0] col;
   } cell_pos_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sh0_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (x < -66'sh0_8000_0000)
         return -32'sh8000_0000;
      else
         return x[31:0];
   endfunction

   // frame index -> atlas row/column; idx < rows^2 so the row fits in 4 bits
   function automatic cell_pos_type split_idx(input logic [7:0] idx, input logic [4:0] rows);
      logic [8:0]   r;
      logic [8:0]   t;
      cell_pos_type p;
      r     = {1'b0, idx};
      p.row = '0;
      for (int k = 3; k >= 0; k--) begin
         t = 9'(rows) << k;
         if (r >= t) begin
            r        = r - t;
            p.row[k] = 1'b1;
         end
      end
      p.col = r[3:0];
      return p;
   endfunction

endpackage

// ===== hw/rtl/psa_divstep.sv =====
module psa_divstep (
   input  logic [psa_pkg::DEN_W-1:0] rem_i,
   input  logic [psa_pkg::DQ_W-1:0]  dq_i,
   input  logic [psa_pkg::DEN_W-1:0] den,
   output logic [psa_pkg::DEN_W-1:0] rem_o,
   output logic [psa_pkg::DQ_W-1:0]  dq_o
);
   import psa_pkg::*;

   // restoring steps: dividend bits shift out of dq's top, quotient bits in at bottom
   always_comb begin
      logic [DEN_W:0]   r2;
      logic [DEN_W-1:0] r;
      logic [DQ_W-1:0]  dq;
      r  = rem_i;
      dq = dq_i;
      for (int s = 0; s < DIV_STEPS; s++) begin
         r2 = {r, dq[DQ_W-1]};
         if (r2 >= {1'b0, den}) begin
            r2 = r2 - {1'b0, den};
            dq = {dq[DQ_W-2:0], 1'b1};
         end else begin
            dq = {dq[DQ_W-2:0], 1'b0};
         end
         r = r2[DEN_W-1:0];
      end
      rem_o = r;
      dq_o  = dq;
   end

endmodule

// ===== hw/rtl/particle_step_with_atlas_frame_core.sv =====
// Particle step with texture atlas frame selection.
//
// Input channel req_*: one particle (position, velocity, gravity factor,
// life span, age, dt) per transfer. Result channel rsp_*: one result per
// input transfer, in order: new position, new y velocity, new age, alive,
// the current and next atlas frame offsets and the blend between them.
// Config channel csr_*: gravity acceleration (index 0) and atlas rows
// (index 1); always ready, write only while the block is idle.
//
// Throughput is one particle per cycle while the receiver accepts results;
// the depth is set by the frame division, a 56-bit long division done
// 4 quotient bits per stage over 14 stages, plus one input, one frame
// split and one table lookup stage.
// Every stage has its own valid bit and a stage loads whenever it or some
// stage ahead of it is empty, so a stalled receiver only stops the input
// once all 17 stages hold particles; nothing is lost or repeated.
// Reset (synchronous) clears all valid bits and restores gravity to about
// -9.81 and atlas rows to 1.
module particle_step_with_atlas_frame_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  psa_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output psa_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  psa_pkg::csr_reg_type  csr_index,
   input  logic [31:0]           csr_wdata
);
   import psa_pkg::*;

   localparam int NSTG      = DIV_STAGES + 3;
   localparam int FRAME_STG = DIV_STAGES + 1;
   localparam int OUT_STG   = DIV_STAGES + 2;
   localparam logic signed [64:0] GLIM = 65'sh0_0000_4000_0000_0000;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_y;
      logic signed [64:0] prod;    // gravity and y step scratch product
      logic signed [48:0] xprod;
      logic signed [48:0] zprod;
      logic [15:0]        dt;
      logic [30:0]        new_age;
      logic               alive;
      logic [4:0]         rows;
      logic [7:0]         last;
      logic [DEN_W-1:0]   den;
      logic [DEN_W-1:0]   rem;
      logic [DQ_W-1:0]    dq;
      cell_pos_type       cur;
      cell_pos_type       nxt;
      logic [15:0]        blend;
      logic [15:0]        fu;
      logic [15:0]        fv;
      logic [15:0]        nu;
      logic [15:0]        nv;
   } pipe_type;

   // config registers
   logic signed [31:0] grav_ff;
   logic [4:0]         rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= -32'sd642908;
         rows_ff <= 5'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GRAVITY: grav_ff <= csr_wdata;
            REG_ROWS:    rows_ff <= csr_wdata[4:0];
            default:     ;
         endcase
      end
   end

   // pipeline
   pipe_type            pipe_ff [NSTG];
   pipe_type            pipe_in [NSTG];
   logic [NSTG-1:0]     valid_ff;
   logic [NSTG:0]       load;

   assign load[NSTG] = rsp_ready;
   for (genvar i = 0; i < NSTG; i++) begin : g_load
      assign load[i] = !valid_ff[i] || load[i+1];
   end
   assign req_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < NSTG; i++) begin
            if (load[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (load[i]) pipe_ff[i] <= pipe_in[i];
      end
   end

   // offset table: (n << 16) / rows, indexed by rows-1 and n
   logic [15:0] ofs_tab [16][16];
   for (genvar r = 0; r < 16; r++) begin : g_ofs_r
      for (genvar n = 0; n < 16; n++) begin : g_ofs_n
         localparam int Den = r + 1;
         localparam int Ofs = (n * 65536) / Den;
         assign ofs_tab[r][n] = 16'(Ofs);
      end
   end

   // division stages
   logic [DEN_W-1:0] div_rem [DIV_STAGES];
   logic [DQ_W-1:0]  div_dq  [DIV_STAGES];
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      psa_divstep u_step (
         .rem_i (pipe_ff[i].rem),
         .dq_i  (pipe_ff[i].dq),
         .den   (pipe_ff[i].den),
         .rem_o (div_rem[i]),
         .dq_o  (div_dq[i])
      );
   end

   // stage 0: products, age, frame dividend
   logic [4:0]         s0_rows;
   logic [8:0]         s0_frames;
   logic [39:0]        s0_num;
   logic [31:0]        s0_age;
   logic signed [16:0] s0_dts;

   always_comb begin
      s0_rows   = (rows_ff == 5'd0) ? 5'd1 : ((rows_ff > 5'd16) ? 5'd16 : rows_ff);
      s0_frames = 9'(s0_rows * s0_rows);
      s0_num    = 40'(req_data.age) * 40'(s0_frames);
      s0_age    = {1'b0, req_data.age} + {16'd0, req_data.time_step};
      s0_dts    = $signed({1'b0, req_data.time_step});
   end

   // working signals of later stages
   logic signed [16:0] s1_dts, s3_dts;
   logic signed [64:0] s1_g1;
   logic signed [47:0] s1_g1c;
   logic signed [64:0] s1_gdt;
   logic signed [48:0] s3_yp;
   logic [DQ_W-1:0]    fr_q;
   logic               fr_ovf;
   logic [7:0]         fr_idx1, fr_idx2;
   logic [3:0]         lk_r;

   always_comb begin
      // stage 0
      pipe_in[0]         = pipe_ff[0];
      pipe_in[0].pos_x   = req_data.pos_x;
      pipe_in[0].pos_y   = req_data.pos_y;
      pipe_in[0].pos_z   = req_data.pos_z;
      pipe_in[0].vel_y   = req_data.vel_y;
      pipe_in[0].prod    = 65'(grav_ff * req_data.gravity_scale);
      pipe_in[0].xprod   = req_data.vel_x * s0_dts;
      pipe_in[0].zprod   = req_data.vel_z * s0_dts;
      pipe_in[0].dt      = req_data.time_step;
      pipe_in[0].new_age = s0_age[31] ? 31'h7FFF_FFFF : s0_age[30:0];
      pipe_in[0].alive   = (s0_age[31] ? 31'h7FFF_FFFF : s0_age[30:0]) < req_data.life_span;
      pipe_in[0].rows    = s0_rows;
      pipe_in[0].last    = 8'(s0_frames - 9'd1);
      pipe_in[0].den     = (req_data.life_span == '0) ? 31'd1 : req_data.life_span;
      pipe_in[0].rem     = '0;
      pipe_in[0].dq      = {1'b0, s0_num[38:0], 16'd0};

      for (int i = 1; i < NSTG; i++) pipe_in[i] = pipe_ff[i-1];

      for (int i = 1; i <= DIV_STAGES; i++) begin
         pipe_in[i].rem = div_rem[i-1];
         pipe_in[i].dq  = div_dq[i-1];
      end

      // stage 1: x/z positions, clamped gravity times dt
      s1_dts = $signed({1'b0, pipe_ff[0].dt});
      s1_g1  = pipe_ff[0].prod >>> FRAC_BITS;
      if (s1_g1 > GLIM)
         s1_g1c = GLIM[47:0];
      else if (s1_g1 < -GLIM)
         s1_g1c = 48'(-GLIM);
      else
         s1_g1c = s1_g1[47:0];
      s1_gdt           = s1_g1c * s1_dts;
      pipe_in[1].prod  = s1_gdt;
      pipe_in[1].pos_x = sat32(66'(pipe_ff[0].pos_x) + 66'(pipe_ff[0].xprod >>> FRAC_BITS));
      pipe_in[1].pos_z = sat32(66'(pipe_ff[0].pos_z) + 66'(pipe_ff[0].zprod >>> FRAC_BITS));

      // stage 2: new y velocity
      pipe_in[2].vel_y = sat32(66'(pipe_ff[1].vel_y) + 66'(pipe_ff[1].prod >>> FRAC_BITS));

      // stage 3: y step
      s3_dts          = $signed({1'b0, pipe_ff[2].dt});
      s3_yp           = pipe_ff[2].vel_y * s3_dts;
      pipe_in[3].prod = 65'(s3_yp);

      // stage 4: y position
      pipe_in[4].pos_y = sat32(66'(pipe_ff[3].pos_y) + 66'(pipe_ff[3].prod >>> FRAC_BITS));

      // frame stage: clamp index, split into row/column
      fr_q    = pipe_ff[FRAME_STG-1].dq;
      fr_ovf  = (|fr_q[DQ_W-1:24]) || (fr_q[23:16] > pipe_ff[FRAME_STG-1].last);
      fr_idx1 = fr_ovf ? pipe_ff[FRAME_STG-1].last : fr_q[23:16];
      fr_idx2 = (fr_idx1 < pipe_ff[FRAME_STG-1].last) ? fr_idx1 + 8'd1 : fr_idx1;
      pipe_in[FRAME_STG].cur   = split_idx(fr_idx1, pipe_ff[FRAME_STG-1].rows);
      pipe_in[FRAME_STG].nxt   = split_idx(fr_idx2, pipe_ff[FRAME_STG-1].rows);
      pipe_in[FRAME_STG].blend = fr_q[15:0];

      // output stage: offsets from table
      lk_r = 4'(pipe_ff[OUT_STG-1].rows - 5'd1);
      pipe_in[OUT_STG].fu = ofs_tab[lk_r][pipe_ff[OUT_STG-1].cur.col];
      pipe_in[OUT_STG].fv = ofs_tab[lk_r][pipe_ff[OUT_STG-1].cur.row];
      pipe_in[OUT_STG].nu = ofs_tab[lk_r][pipe_ff[OUT_STG-1].nxt.col];
      pipe_in[OUT_STG].nv = ofs_tab[lk_r][pipe_ff[OUT_STG-1].nxt.row];
   end

   assign rsp_valid = valid_ff[OUT_STG];

   always_comb begin
      rsp_data.new_pos_x    = pipe_ff[OUT_STG].pos_x;
      rsp_data.new_pos_y    = pipe_ff[OUT_STG].pos_y;
      rsp_data.new_pos_z    = pipe_ff[OUT_STG].pos_z;
      rsp_data.new_vel_y    = pipe_ff[OUT_STG].vel_y;
      rsp_data.new_age      = pipe_ff[OUT_STG].new_age;
      rsp_data.alive        = pipe_ff[OUT_STG].alive;
      rsp_data.frame_u      = pipe_ff[OUT_STG].fu;
      rsp_data.frame_v      = pipe_ff[OUT_STG].fv;
      rsp_data.next_frame_u = pipe_ff[OUT_STG].nu;
      rsp_data.next_frame_v = pipe_ff[OUT_STG].nv;
      rsp_data.frame_blend  = pipe_ff[OUT_STG].blend;
   end

   // input only backs up when every stage holds a particle
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input blocked with a bubble in the pipeline");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STAGES] |-> (pipe_ff[DIV_STAGES].rem < pipe_ff[DIV_STAGES].den))
      else $error("division remainder out of range");

   // an accepted particle lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted particle lost at pipeline entry");

   // a waiting result holds its stage
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pipe_ff[OUT_STG].blend))
      else $error("stalled result changed");

endmodule
